[sv/tcs_pkg.sv]
// Shared types and constants for the text console cursor and scroll block.
package tcs_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS = 25;
    localparam int CELLS = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int SCAN_W = $clog2(CELLS + COLUMNS);
    localparam int COL_W = 7;
    localparam int ROW_W = 5;
    localparam int CELL_W = 16;

    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;
    localparam logic [7:0] NEWLINE_CODE = 8'd10;

    typedef enum logic
    {
        CMD_PUT = 1'b0,
        CMD_READ = 1'b1
    } cmd_code_t;

    typedef struct packed
    {
        logic [0:0] command;
        logic [7:0] char_code;
        logic [7:0] color;
        logic [10:0] cell_index;
    } in_word_t;

    typedef struct packed
    {
        logic [COL_W-1:0] cursor_col;
        logic [ROW_W-1:0] cursor_row;
        logic [0:0] scrolled;
        logic [CELL_W-1:0] cell_word;
    } out_word_t;

    typedef struct packed
    {
        logic accept;
        logic clear_step;
        logic scroll_step;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed
    {
        logic need_scroll;
        logic clear_last;
        logic scroll_last;
        logic out_free;
    } dp_status_t;

endpackage

[sv/text_console_cursor_scroll_core.sv]
// Top level of the text console: an 80 by 25 cell screen store with a cursor.
//
// Input words arrive on in_valid/in_ready/in_data; each one gives exactly one
// result word on out_valid/out_ready/out_data. A put word writes the character
// and color at the cursor and advances it, a newline moves to the next row, and
// a read word returns one stored cell, or zero for an index past the store.
// An ordinary put or read has its result loaded into the output register in the
// done state that follows acceptance, once that register is free.
// A put that runs past the last row scrolls the store up by one row: the scan
// reads one cell and writes one cell a cycle through the store's read and write
// ports and then blanks the bottom row. Such a put loads its result into the
// output register only after the scan has finished.
// One word is in flight at a time; the next word is taken once the current
// result sits in the output register, which holds it while the receiver stalls.
// If that register is still full when a new result is ready, the block waits.
// After reset the store is cleared to blank cells, with the cursor at row 0,
// column 0; in_ready stays low during the clearing pass.
module text_console_cursor_scroll_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  tcs_pkg::in_word_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output tcs_pkg::out_word_t  out_data
);

    tcs_pkg::dp_cmd_t cmd;
    tcs_pkg::dp_status_t status;

    tcs_controller u_controller
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    tcs_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

[sv/tcs_datapath.sv]
// Datapath: screen store, cursor registers, scan counter and result register.
module tcs_datapath
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  tcs_pkg::dp_cmd_t     cmd,
    output tcs_pkg::dp_status_t  status,
    input  tcs_pkg::in_word_t    in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output tcs_pkg::out_word_t   out_data
);

    logic [tcs_pkg::CELL_W-1:0] mem [tcs_pkg::CELLS];
    logic [tcs_pkg::CELL_W-1:0] mem_q_reg;

    logic [tcs_pkg::COL_W-1:0] col_reg, col_next;
    logic [tcs_pkg::ROW_W-1:0] row_reg, row_next;
    logic [tcs_pkg::ADDR_W-1:0] base_reg, base_next;
    logic [tcs_pkg::SCAN_W-1:0] scan_reg, scan_next;
    logic mv_valid_reg, mv_valid_next;
    logic mv_blank_reg, mv_blank_next;
    logic [tcs_pkg::ADDR_W-1:0] mv_addr_reg, mv_addr_next;
    logic scrolled_reg, scrolled_next;
    logic is_read_reg, is_read_next;
    logic in_range_reg, in_range_next;
    logic out_valid_reg, out_valid_next;
    tcs_pkg::out_word_t out_reg, out_next;

    logic is_put;
    logic is_newline;
    logic line_end;
    logic last_row;
    logic scan_in_store;
    logic [tcs_pkg::ADDR_W-1:0] cursor_addr;

    logic wr_en;
    logic [tcs_pkg::ADDR_W-1:0] wr_addr;
    logic [tcs_pkg::CELL_W-1:0] wr_data;
    logic rd_en;
    logic [tcs_pkg::ADDR_W-1:0] rd_addr;

    assign is_put = (in_data.command == tcs_pkg::CMD_PUT);
    assign is_newline = (in_data.char_code == tcs_pkg::NEWLINE_CODE);
    assign line_end = is_newline || (col_reg == tcs_pkg::COL_W'(tcs_pkg::COLUMNS - 1));
    assign last_row = (row_reg == tcs_pkg::ROW_W'(tcs_pkg::ROWS - 1));
    assign cursor_addr = base_reg + tcs_pkg::ADDR_W'(col_reg);
    assign scan_in_store = (scan_reg < tcs_pkg::SCAN_W'(tcs_pkg::CELLS));

    assign status.need_scroll = is_put && line_end && last_row;
    assign status.clear_last = (scan_reg == tcs_pkg::SCAN_W'(tcs_pkg::CELLS - 1));
    assign status.scroll_last =
        (scan_reg == tcs_pkg::SCAN_W'(tcs_pkg::CELLS + tcs_pkg::COLUMNS - 1));
    assign status.out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        wr_en = 1'b0;
        wr_addr = cursor_addr;
        wr_data = {in_data.color, in_data.char_code};
        if (cmd.clear_step)
        begin
            wr_en = 1'b1;
            wr_addr = scan_reg[tcs_pkg::ADDR_W-1:0];
            wr_data = tcs_pkg::BLANK_CELL;
        end
        else if (mv_valid_reg)
        begin
            wr_en = 1'b1;
            wr_addr = mv_addr_reg;
            wr_data = mv_blank_reg ? tcs_pkg::BLANK_CELL : mem_q_reg;
        end
        else if (cmd.accept && is_put && !is_newline)
        begin
            wr_en = 1'b1;
        end
    end

    always_comb
    begin
        rd_en = 1'b0;
        rd_addr = in_data.cell_index;
        if (cmd.scroll_step)
        begin
            rd_en = scan_in_store;
            rd_addr = scan_reg[tcs_pkg::ADDR_W-1:0];
        end
        else if (cmd.accept && !is_put)
        begin
            rd_en = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        base_next = base_reg;
        scan_next = scan_reg;
        mv_valid_next = 1'b0;
        mv_blank_next = mv_blank_reg;
        mv_addr_next = mv_addr_reg;
        scrolled_next = scrolled_reg;
        is_read_next = is_read_reg;
        in_range_next = in_range_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next = out_reg;

        if (cmd.clear_step)
        begin
            scan_next = scan_reg + 1'b1;
        end

        if (cmd.accept)
        begin
            is_read_next = !is_put;
            in_range_next = (in_data.cell_index < 11'(tcs_pkg::CELLS));
            scrolled_next = 1'b0;
            if (is_put)
            begin
                if (line_end)
                begin
                    col_next = '0;
                    if (last_row)
                    begin
                        scrolled_next = 1'b1;
                        scan_next = tcs_pkg::SCAN_W'(tcs_pkg::COLUMNS);
                    end
                    else
                    begin
                        row_next = row_reg + 1'b1;
                        base_next = base_reg + tcs_pkg::ADDR_W'(tcs_pkg::COLUMNS);
                    end
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
        end

        if (cmd.scroll_step)
        begin
            mv_valid_next = 1'b1;
            mv_blank_next = !scan_in_store;
            mv_addr_next = tcs_pkg::ADDR_W'(scan_reg - tcs_pkg::SCAN_W'(tcs_pkg::COLUMNS));
            scan_next = scan_reg + 1'b1;
        end

        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
            out_next.cursor_col = col_reg;
            out_next.cursor_row = row_reg;
            out_next.scrolled = scrolled_reg;
            out_next.cell_word = (is_read_reg && in_range_reg) ? mem_q_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            base_reg <= '0;
            scan_reg <= '0;
            mv_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            base_reg <= base_next;
            scan_reg <= scan_next;
            mv_valid_reg <= mv_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mv_blank_reg <= mv_blank_next;
        mv_addr_reg <= mv_addr_next;
        scrolled_reg <= scrolled_next;
        is_read_reg <= is_read_next;
        in_range_reg <= in_range_next;
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

endmodule

[sv/tcs_controller.sv]
// Controller: sequences store clearing, item execution, scrolling and result hand-off.
module tcs_controller
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  tcs_pkg::dp_status_t  status,
    output tcs_pkg::dp_cmd_t     cmd
);

    typedef enum logic [1:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_SCROLL,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = status.need_scroll ? ST_SCROLL : ST_DONE;
                end
            end
            ST_SCROLL:
            begin
                cmd.scroll_step = 1'b1;
                if (status.scroll_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the text console cursor and scroll core.
module testbench;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LONG_HOLD = 300;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    tcs_pkg::in_word_t   in_data;
    logic                out_valid;
    logic                out_ready;
    tcs_pkg::out_word_t  out_data;

    logic [tcs_pkg::CELL_W-1:0] screen_mirror [tcs_pkg::CELLS];
    int                         cur_col;
    int                         cur_row;
    tcs_pkg::out_word_t         console_replies_q [$];
    int                         mismatch_count;
    int                         quiet_cycles;
    int                         hold_len;
    bit                         sender_idles;
    bit                         receiver_stalls;

    text_console_cursor_scroll_core i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Applies one accepted word to the mirrored screen and queues the reply it causes.
    task automatic console_apply(input tcs_pkg::in_word_t w);
        tcs_pkg::out_word_t reply;
        int                 at;
        int                 k;
        reply = '0;
        if (tcs_pkg::cmd_code_t'(w.command) == tcs_pkg::CMD_READ)
        begin
            if (w.cell_index < tcs_pkg::CELLS)
            begin
                reply.cell_word = screen_mirror[w.cell_index];
            end
        end
        else
        begin
            if (w.char_code == tcs_pkg::NEWLINE_CODE)
            begin
                cur_col = 0;
                cur_row++;
            end
            else
            begin
                at = cur_row * tcs_pkg::COLUMNS + cur_col;
                screen_mirror[at] = {w.color, w.char_code};
                cur_col++;
                if (cur_col >= tcs_pkg::COLUMNS)
                begin
                    cur_col = 0;
                    cur_row++;
                end
            end
            if (cur_row >= tcs_pkg::ROWS)
            begin
                for (k = 0; k < tcs_pkg::CELLS - tcs_pkg::COLUMNS; k++)
                begin
                    screen_mirror[k] = screen_mirror[k + tcs_pkg::COLUMNS];
                end
                for (k = tcs_pkg::CELLS - tcs_pkg::COLUMNS; k < tcs_pkg::CELLS; k++)
                begin
                    screen_mirror[k] = tcs_pkg::BLANK_CELL;
                end
                cur_row = tcs_pkg::ROWS - 1;
                reply.scrolled = 1'b1;
            end
        end
        reply.cursor_col = tcs_pkg::COL_W'(cur_col);
        reply.cursor_row = tcs_pkg::ROW_W'(cur_row);
        console_replies_q.push_back(reply);
    endtask

    function automatic tcs_pkg::in_word_t put_word(input logic [7:0] ch,
                                                   input logic [7:0] attr);
        tcs_pkg::in_word_t w;
        w.command = tcs_pkg::CMD_PUT;
        w.char_code = ch;
        w.color = attr;
        w.cell_index = 11'($urandom_range(0, 2047));
        return w;
    endfunction

    function automatic tcs_pkg::in_word_t read_word(input int idx);
        tcs_pkg::in_word_t w;
        w.command = tcs_pkg::CMD_READ;
        w.char_code = 8'($urandom_range(0, 255));
        w.color = 8'($urandom_range(0, 255));
        w.cell_index = 11'(idx);
        return w;
    endfunction

    function automatic logic [7:0] printable_char();
        logic [7:0] ch;
        ch = 8'($urandom_range(0, 255));
        if (ch == tcs_pkg::NEWLINE_CODE)
        begin
            ch = 8'h0B;
        end
        return ch;
    endfunction

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // Offers one word, holds it until the core takes it, then predicts its reply.
    task automatic offer_word(input tcs_pkg::in_word_t w);
        if (sender_idles && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= w;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        console_apply(w);
    endtask

    task automatic send_random_item();
        int pick;
        int lo_row;
        pick = $urandom_range(0, 99);
        lo_row = (cur_row > 0) ? cur_row - 1 : 0;
        if (pick < 15)
        begin
            offer_word(read_word($urandom_range(0, 2047)));
        end
        else if (pick < 30)
        begin
            offer_word(read_word($urandom_range(lo_row, cur_row) * tcs_pkg::COLUMNS
                                 + $urandom_range(0, tcs_pkg::COLUMNS - 1)));
        end
        else if (pick < 35)
        begin
            offer_word(put_word(tcs_pkg::NEWLINE_CODE, any_byte()));
        end
        else
        begin
            offer_word(put_word(any_byte(), any_byte()));
        end
    endtask

    task automatic check_reset_contents();
        offer_word(read_word(0));
        offer_word(read_word(tcs_pkg::CELLS - 1));
        offer_word(read_word(tcs_pkg::CELLS));
        offer_word(read_word(2047));
        offer_word(read_word(1000));
    endtask

    task automatic check_put_extremes();
        offer_word(put_word(8'h00, 8'h00));
        offer_word(put_word(8'hFF, 8'hFF));
        offer_word(put_word(tcs_pkg::NEWLINE_CODE, 8'hFF));
        offer_word(read_word(0));
        offer_word(read_word(1));
        offer_word(read_word(2));
        offer_word(read_word(tcs_pkg::COLUMNS));
        offer_word(put_word(8'h41, 8'h0F));
        offer_word(read_word(tcs_pkg::COLUMNS));
    endtask

    task automatic check_line_wrap();
        int i;
        do
        begin
            offer_word(put_word(printable_char(), any_byte()));
        end
        while (cur_col != 0);
        for (i = 0; i < 6; i++)
        begin
            offer_word(read_word((cur_row - 1) * tcs_pkg::COLUMNS
                                 + $urandom_range(0, tcs_pkg::COLUMNS - 1)));
        end
        offer_word(read_word((cur_row - 1) * tcs_pkg::COLUMNS + tcs_pkg::COLUMNS - 1));
    endtask

    task automatic check_scroll();
        int i;
        while (cur_row != tcs_pkg::ROWS - 1)
        begin
            offer_word(put_word(tcs_pkg::NEWLINE_CODE, any_byte()));
        end
        repeat (3) offer_word(put_word(printable_char(), any_byte()));
        offer_word(put_word(tcs_pkg::NEWLINE_CODE, any_byte()));
        for (i = 0; i < 3; i++)
        begin
            offer_word(read_word((tcs_pkg::ROWS - 2) * tcs_pkg::COLUMNS + i));
        end
        offer_word(read_word((tcs_pkg::ROWS - 1) * tcs_pkg::COLUMNS));
        repeat (tcs_pkg::COLUMNS) offer_word(put_word(printable_char(), any_byte()));
        for (i = 0; i < 4; i++)
        begin
            offer_word(read_word((tcs_pkg::ROWS - 2) * tcs_pkg::COLUMNS
                                 + $urandom_range(0, tcs_pkg::COLUMNS - 1)));
        end
        offer_word(read_word(tcs_pkg::CELLS - 1));
    endtask

    task automatic check_random_traffic();
        repeat (1500) send_random_item();
    endtask

    task automatic check_output_backpressure();
        hold_len = LONG_HOLD;
        repeat (30) send_random_item();
    endtask

    task automatic check_steady_stream();
        sender_idles = 1'b0;
        receiver_stalls = 1'b0;
        repeat (150) send_random_item();
    endtask

    // Receiver: random stall bursts, and one long hold when requested.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_len != 0)
            begin
                out_ready <= 1'b0;
                repeat (hold_len) @(posedge clk);
                hold_len = 0;
                out_ready <= 1'b1;
            end
            else if (receiver_stalls && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (console_replies_q.size() == 0)
            begin
                $error("reply word with nothing outstanding: %h", out_data);
                mismatch_count++;
            end
            else
            begin
                tcs_pkg::out_word_t want;
                want = console_replies_q.pop_front();
                if (out_data.cursor_col !== want.cursor_col)
                begin
                    $error("cursor_col expected %0d actual %0d",
                           want.cursor_col, out_data.cursor_col);
                    mismatch_count++;
                end
                if (out_data.cursor_row !== want.cursor_row)
                begin
                    $error("cursor_row expected %0d actual %0d",
                           want.cursor_row, out_data.cursor_row);
                    mismatch_count++;
                end
                if (out_data.scrolled !== want.scrolled)
                begin
                    $error("scrolled expected %0d actual %0d",
                           want.scrolled, out_data.scrolled);
                    mismatch_count++;
                end
                if (out_data.cell_word !== want.cell_word)
                begin
                    $error("cell_word expected %h actual %h",
                           want.cell_word, out_data.cell_word);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("text_console_cursor_scroll_core verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        int k;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        mismatch_count = 0;
        quiet_cycles = 0;
        hold_len = 0;
        sender_idles = 1'b1;
        receiver_stalls = 1'b1;
        cur_col = 0;
        cur_row = 0;
        for (k = 0; k < tcs_pkg::CELLS; k++)
        begin
            screen_mirror[k] = tcs_pkg::BLANK_CELL;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        check_reset_contents();
        check_put_extremes();
        check_line_wrap();
        check_scroll();
        check_random_traffic();
        check_output_backpressure();
        check_steady_stream();

        in_valid <= 1'b0;
        while (console_replies_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("text_console_cursor_scroll_core verification clean");
        end
        else
        begin
            $display("text_console_cursor_scroll_core verification failed");
        end
        $finish;
    end

endmodule

[files.f]
sv/tcs_pkg.sv
sv/tcs_datapath.sv
sv/tcs_controller.sv
sv/text_console_cursor_scroll_core.sv
tb/testbench.sv
